/* hw/rtl/drt_pkg.sv */
// Shared types and codes for the disjoint range table.
package drt_pkg;

  // Result status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERLAP   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Input action codes.
  localparam logic ACT_INSERT = 1'b0;

  // Operation class decided by the front end.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REJECT,
    OP_REMOVE
  } op_t;

  // One queued operation.
  typedef struct packed {
    op_t         op;
    logic [63:0] range_start;
    logic [63:0] range_end;
  } item_t;

endpackage

/* hw/rtl/drt_front.sv */
// Front end: takes commands, classifies them and holds them in a two-entry queue.
module drt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic           in_action,
  input  logic [63:0]    in_range_start,
  input  logic [63:0]    in_range_end,
  output logic           q_valid,
  output drt_pkg::item_t q_item,
  input  logic           q_pop
);
  import drt_pkg::*;

  item_t       q_mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  fill_r;
  logic        push;
  item_t       new_item;

  // An insert with an inverted range is rejected without touching the table.
  always_comb begin
    new_item.range_start = in_range_start;
    new_item.range_end   = in_range_end;
    if (in_action == ACT_INSERT) begin
      new_item.op = (in_range_start > in_range_end) ? OP_REJECT : OP_INSERT;
    end else begin
      new_item.op = OP_REMOVE;
    end
  end

  assign busy    = (fill_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill_r != 2'd0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, q_pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

/* hw/rtl/drt_back.sv */
// Back end: scans the slot memory one slot per cycle and applies each operation.
module drt_back #(
  parameter int ENTRIES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  drt_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  output logic [1:0]     out_status,
  output logic [5:0]     out_entry_count,
  output logic           out_is_empty,
  output logic [63:0]    out_leftmost_start,
  output logic [63:0]    out_leftmost_end
);
  import drt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t        state_r;
  item_t         cur_r;
  logic [IW-1:0] idx_r;
  logic          chk_v_r;
  logic [IW-1:0] chk_idx_r;
  logic [63:0]   rd_start_r;
  logic [63:0]   rd_end_r;
  logic [63:0]   mem_start [ENTRIES];
  logic [63:0]   mem_end   [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [CW-1:0] cnt_r;

  // Scan accumulators.
  logic          ov_r;
  logic          found_r;
  logic [IW-1:0] found_idx_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;
  logic          any_r;
  logic [63:0]   min_s_r;
  logic [63:0]   min_e_r;

  logic          ins_ok;
  logic          rem_ok;
  logic          new_min;
  logic [CW-1:0] cnt_fin;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Outcome of the finished scan.
  always_comb begin
    ins_ok  = (cur_r.op == OP_INSERT) && !ov_r && free_found_r;
    rem_ok  = (cur_r.op == OP_REMOVE) && found_r;
    new_min = ins_ok && (!any_r || (cur_r.range_end < min_e_r));
    if (ins_ok) begin
      cnt_fin = cnt_r + CW'(1);
    end else if (rem_ok) begin
      cnt_fin = cnt_r - CW'(1);
    end else begin
      cnt_fin = cnt_r;
    end
  end

  // Slot memory: one read per scan cycle, one write when an insert lands.
  always_ff @(posedge clk) begin
    rd_start_r <= mem_start[idx_r];
    rd_end_r   <= mem_end[idx_r];
    if ((state_r == S_FIN) && ins_ok) begin
      mem_start[free_idx_r] <= cur_r.range_start;
      mem_end[free_idx_r]   <= cur_r.range_end;
    end
  end

  // Sequencer, slot evaluation and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      chk_v_r   <= 1'b0;
      valid_r   <= '0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      chk_v_r   <= (state_r == S_SCAN);
      chk_idx_r <= idx_r;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r        <= q_item;
            idx_r        <= '0;
            ov_r         <= 1'b0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            any_r        <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_r == LAST) begin
            state_r <= S_DRAIN;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (ins_ok) begin
            valid_r[free_idx_r] <= 1'b1;
          end
          if (rem_ok) begin
            valid_r[found_idx_r] <= 1'b0;
          end
          cnt_r     <= cnt_fin;
          out_valid <= 1'b1;
          case (cur_r.op)
            OP_INSERT: out_status <= ov_r ? ST_OVERLAP :
                                     (free_found_r ? ST_DONE : ST_FULL);
            OP_REMOVE: out_status <= found_r ? ST_DONE : ST_NOT_FOUND;
            default:   out_status <= ST_OVERLAP;
          endcase
          out_entry_count <= 6'(cnt_fin);
          out_is_empty    <= (cnt_fin == '0);
          if (new_min) begin
            out_leftmost_start <= cur_r.range_start;
            out_leftmost_end   <= cur_r.range_end;
          end else if (any_r) begin
            out_leftmost_start <= min_s_r;
            out_leftmost_end   <= min_e_r;
          end else begin
            out_leftmost_start <= '0;
            out_leftmost_end   <= '0;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      // Evaluate the slot whose data arrived from the memory this cycle.
      if (chk_v_r) begin
        if (valid_r[chk_idx_r]) begin
          if ((rd_start_r <= cur_r.range_end) && (cur_r.range_start <= rd_end_r)) begin
            ov_r <= 1'b1;
          end
          if ((cur_r.op == OP_REMOVE) && (rd_end_r == cur_r.range_end)) begin
            found_r     <= 1'b1;
            found_idx_r <= chk_idx_r;
          end else if (!any_r || (rd_end_r < min_e_r)) begin
            any_r   <= 1'b1;
            min_s_r <= rd_start_r;
            min_e_r <= rd_end_r;
          end
        end else if (!free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= chk_idx_r;
        end
      end
    end
  end

endmodule

/* hw/rtl/disjoint_range_table.sv */
// Top level of the disjoint range table: front queue plus scanning back end.
//
// A table of up to ENTRIES non-overlapping closed ranges. Each command is
// taken when start is high and busy is low; up to two commands wait in a
// queue while the back end works. The back end scans the slot memory one
// slot per cycle through its single read port and pops no new command from
// the queue until it has passed through its scan, drain and finish states.
// Each result is shown for one cycle with out_valid high and must be taken
// then; the receiver cannot stall.
module disjoint_range_table #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_end,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_count,
  output logic        out_is_empty,
  output logic [63:0] out_leftmost_start,
  output logic [63:0] out_leftmost_end
);
  import drt_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Command intake and queue.
  drt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  // Table scan and update.
  drt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_is_empty       (out_is_empty),
    .out_leftmost_start (out_leftmost_start),
    .out_leftmost_end   (out_leftmost_end)
  );

endmodule

/* hw/rtl/drt_checker.sv */
// Port-level checks for the disjoint range table, bound to the top level.
module drt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [5:0]  out_entry_count,
  input logic        out_is_empty,
  input logic [63:0] out_leftmost_start,
  input logic [63:0] out_leftmost_end
);
  import drt_pkg::*;

  // Results never come in back-to-back cycles.
  a_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in consecutive cycles");

  // No result right after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // An empty table reports a zero count and zero leftmost range.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_entry_count == 6'd0) && (out_leftmost_start == 64'd0) &&
      (out_leftmost_end == 64'd0))
    else $error("empty table with stale contents");

  // A table left empty cannot have been full.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_status != ST_FULL))
    else $error("full status on an empty table");

endmodule

bind disjoint_range_table drt_checker u_drt_checker (.*);

/* tb/disjoint_range_table_tb.sv */
// Self-checking testbench for the disjoint range table: directed and random commands.
module disjoint_range_table_tb;
  import drt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;
  localparam logic [63:0] MAXV = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic ACT_REMOVE = 1'b1;

  // One expected result.
  typedef struct {
    logic [1:0]  status;
    logic [5:0]  count;
    logic        empty;
    logic [63:0] lm_start;
    logic [63:0] lm_end;
  } result_t;

  // One directed command; known results are typed in where chk is set.
  typedef struct {
    logic        act;
    logic [63:0] rs;
    logic [63:0] re;
    bit          chk;
    result_t     res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_action;
  logic [63:0] in_range_start;
  logic [63:0] in_range_end;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_entry_count;
  logic        out_is_empty;
  logic [63:0] out_leftmost_start;
  logic [63:0] out_leftmost_end;

  // Shadow copy of the range table.
  bit          tbl_valid [SLOTS];
  logic [63:0] tbl_start [SLOTS];
  logic [63:0] tbl_end   [SLOTS];

  result_t pending_results[$];
  bit      failed;
  int      idle_pct;

  disjoint_range_table #(.ENTRIES(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_range_start(in_range_start),
    .in_range_end(in_range_end), .out_valid(out_valid),
    .out_status(out_status), .out_entry_count(out_entry_count),
    .out_is_empty(out_is_empty), .out_leftmost_start(out_leftmost_start),
    .out_leftmost_end(out_leftmost_end)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one command to the shadow table and return the resulting report.
  function automatic result_t apply_range_op(logic act, logic [63:0] rs, logic [63:0] re);
    result_t r;
    int free_slot;
    bit hit;
    bit any;
    free_slot = -1;
    hit = 0;
    any = 0;
    r.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (rs > re) begin
        r.status = ST_OVERLAP;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_start[i] <= re && rs <= tbl_end[i]) hit = 1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit) r.status = ST_OVERLAP;
        else if (free_slot < 0) r.status = ST_FULL;
        else begin
          tbl_valid[free_slot] = 1;
          tbl_start[free_slot] = rs;
          tbl_end[free_slot] = re;
        end
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < SLOTS; i++) begin
        if (!hit && tbl_valid[i] && tbl_end[i] == re) begin
          tbl_valid[i] = 0;
          hit = 1;
          r.status = ST_DONE;
        end
      end
    end
    r.count = '0;
    r.lm_start = '0;
    r.lm_end = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        r.count++;
        if (!any || tbl_end[i] < r.lm_end) begin
          any = 1;
          r.lm_start = tbl_start[i];
          r.lm_end = tbl_end[i];
        end
      end
    end
    r.empty = !any;
    return r;
  endfunction

  // Present one command and wait for its transfer; record what it must produce.
  task automatic send_cmd(logic act, logic [63:0] rs, logic [63:0] re,
                          bit chk, result_t typed);
    result_t r;
    logic    was_busy;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_range_start <= rs;
    in_range_end <= re;
    // Busy is sampled mid-cycle, so it is the value that the next edge sees.
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    r = apply_range_op(act, rs, re);
    pending_results.push_back(chk ? typed : r);
  endtask

  // Pick the end of a stored range, or a random value if the table is empty.
  function automatic logic [63:0] stored_end();
    int idx[$];
    for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) idx.push_back(i);
    if (idx.size() == 0) return {$urandom, $urandom};
    return tbl_end[idx[$urandom_range(idx.size() - 1)]];
  endfunction

  // Compare every result transfer with the oldest expectation; the ports are
  // sampled mid-cycle, where they hold what the next rising edge takes.
  always @(negedge clk) begin
    result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          failed = 1;
        end
        if (out_entry_count !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, out_entry_count);
          failed = 1;
        end
        if (out_is_empty !== e.empty) begin
          $error("is_empty: expected %0d, got %0d", e.empty, out_is_empty);
          failed = 1;
        end
        if (out_leftmost_start !== e.lm_start) begin
          $error("leftmost_start: expected %h, got %h", e.lm_start, out_leftmost_start);
          failed = 1;
        end
        if (out_leftmost_end !== e.lm_end) begin
          $error("leftmost_end: expected %h, got %h", e.lm_end, out_leftmost_end);
          failed = 1;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_t rows[$];
    result_t none;
    logic [63:0] rs;
    logic [63:0] re;
    logic [63:0] len;
    int pick;
    int phase_pct[4];
    phase_pct = '{0, 58, 0, 32};
    none = '{ST_DONE, 6'd0, 1'b0, 64'd0, 64'd0};
    failed = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = 1'b0;
    in_range_start = '0;
    in_range_end = '0;
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands: empty table, touching ends, inverted range, extremes.
    rows.push_back('{ACT_REMOVE, 64'd0, 64'd5, 1, '{ST_NOT_FOUND, 6'd0, 1'b1, 64'd0, 64'd0}});
    rows.push_back('{ACT_INSERT, 64'd10, 64'd20, 1, '{ST_DONE, 6'd1, 1'b0, 64'd10, 64'd20}});
    rows.push_back('{ACT_INSERT, 64'd20, 64'd30, 1, '{ST_OVERLAP, 6'd1, 1'b0, 64'd10, 64'd20}});
    rows.push_back('{ACT_INSERT, 64'd25, 64'd21, 1, '{ST_OVERLAP, 6'd1, 1'b0, 64'd10, 64'd20}});
    rows.push_back('{ACT_INSERT, 64'd0, 64'd0, 1, '{ST_DONE, 6'd2, 1'b0, 64'd0, 64'd0}});
    rows.push_back('{ACT_INSERT, MAXV, MAXV, 1, '{ST_DONE, 6'd3, 1'b0, 64'd0, 64'd0}});
    rows.push_back('{ACT_INSERT, 64'd21, MAXV - 1, 1, '{ST_DONE, 6'd4, 1'b0, 64'd0, 64'd0}});
    rows.push_back('{ACT_INSERT, 64'd0, MAXV, 1, '{ST_OVERLAP, 6'd4, 1'b0, 64'd0, 64'd0}});
    rows.push_back('{ACT_REMOVE, MAXV, 64'd0, 1, '{ST_DONE, 6'd3, 1'b0, 64'd10, 64'd20}});
    rows.push_back('{ACT_REMOVE, 64'd0, 64'd21, 1, '{ST_NOT_FOUND, 6'd3, 1'b0, 64'd10, 64'd20}});
    rows.push_back('{ACT_REMOVE, 64'd0, 64'd20, 0, none});
    rows.push_back('{ACT_REMOVE, 64'd0, MAXV, 0, none});
    rows.push_back('{ACT_REMOVE, 64'd0, MAXV - 1, 1, '{ST_DONE, 6'd0, 1'b1, 64'd0, 64'd0}});
    foreach (rows[i]) send_cmd(rows[i].act, rows[i].rs, rows[i].re, rows[i].chk, rows[i].res);

    // Fill the table past capacity, hit overlap and full together, then drain it.
    for (int i = 0; i < SLOTS + 2; i++)
      send_cmd(ACT_INSERT, 64'd100 + 10 * i, 64'd105 + 10 * i, 0, none);
    send_cmd(ACT_INSERT, 64'd103, 64'd103, 0, none);
    for (int i = 0; i < SLOTS; i++)
      send_cmd(ACT_REMOVE, 64'd0, 64'd105 + 10 * i, 0, none);

    // Random commands under each sender idling pattern.
    foreach (phase_pct[p]) begin
      idle_pct = phase_pct[p];
      for (int n = 0; n < 240; n++) begin
        pick = $urandom_range(99);
        rs = {$urandom, $urandom};
        len = {$urandom, $urandom} >> $urandom_range(63);
        re = (rs > MAXV - len) ? MAXV : rs + len;
        if (pick < 55) begin
          send_cmd(ACT_INSERT, rs, re, 0, none);
        end else if (pick < 85) begin
          send_cmd(ACT_REMOVE, rs, stored_end(), 0, none);
        end else if (pick < 90) begin
          send_cmd(ACT_INSERT, re, rs, 0, none);
        end else if (pick < 95) begin
          // A point range at a stored end overlaps it, unless the table is empty.
          re = stored_end();
          send_cmd(ACT_INSERT, re, re, 0, none);
        end else begin
          send_cmd(ACT_REMOVE, rs, re, 0, none);
        end
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 10) @(posedge clk);
    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/drt_pkg.sv
hw/rtl/drt_front.sv
hw/rtl/drt_back.sv
hw/rtl/disjoint_range_table.sv
hw/rtl/drt_checker.sv
tb/disjoint_range_table_tb.sv
